@@ sv/mpbs_pkg.sv @@
// ----------------------------------------------------------------------------
// mpbs_pkg
// Shared types, sizes and helpers for the multi-pattern byte scanner.
// ----------------------------------------------------------------------------
package mpbs_pkg;

	localparam int NUM_PATTERNS    = 16;
	localparam int MAX_PATTERN_LEN = 64;

	localparam int SLOT_W  = $clog2(NUM_PATTERNS);
	localparam int BPOS_W  = $clog2(MAX_PATTERN_LEN);
	localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
	localparam int ACT_W   = $clog2(NUM_PATTERNS + 1);
	localparam int CNT_W   = 5;
	localparam int POS_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int WIN_W   = MAX_PATTERN_LEN * BYTE_W;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// word index of the pattern count register
	localparam logic REG_PATTERN_COUNT = 1'b0;

	typedef enum logic [1:0] {
		FN_LOAD    = 2'd0,
		FN_SET_LEN = 2'd1,
		FN_SCAN    = 2'd2,
		FN_RESTART = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              load;
		logic              set_len;
		logic              restart;
		logic              scan;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_slot;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic hits_any;
		logic hits_one;
		logic out_free;
	} sts_t;

	// lowest set bit of the hit vector
	function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_PATTERNS-1:0] v);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = SLOT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ sv/mpbs_ram.sv @@
// ----------------------------------------------------------------------------
// mpbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/mpbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpbs_ctrl
// Sequencer: takes items, steps one slot per cycle, then hands out reports.
// ----------------------------------------------------------------------------
module mpbs_ctrl import mpbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       func,
	input  logic [ACT_W-1:0] active_cnt,
	input  sts_t             sts,
	output logic             in_ready,
	output cmd_t             cmd
);

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] slot_q;
	func_t             fn;
	logic              last_slot;

	assign fn        = func_t'(func);
	assign last_slot = ({1'b0, slot_q} == ACT_W'(active_cnt - ACT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				slot_q <= slot_q + SLOT_W'(1);
			end else begin
				slot_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && fn == FN_SCAN && active_cnt != '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_slot) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.hits_any || (sts.out_free && sts.hits_one)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.rd_slot = slot_q;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load    = in_valid && fn == FN_LOAD;
				cmd.set_len = in_valid && fn == FN_SET_LEN;
				cmd.scan    = in_valid && fn == FN_SCAN;
				cmd.restart = in_valid && fn == FN_RESTART;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				cmd.emit = sts.hits_any && sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/mpbs_dp.sv @@
// ----------------------------------------------------------------------------
// mpbs_dp
// Datapath: signature table, window, slot compare, hit vector, report register.
// ----------------------------------------------------------------------------
module mpbs_dp import mpbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [SLOT_W-1:0] slot_select,
	input  logic [BPOS_W-1:0] byte_position,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic [LEN_W-1:0]  pattern_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] matched_slot,
	output logic [POS_W-1:0]  match_start,
	output logic              last_match
);

	logic [BYTE_W-1:0] win_q [MAX_PATTERN_LEN];  // [0] newest
	logic [LEN_W-1:0]  len_q [NUM_PATTERNS];
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  here_q;
	logic [LEN_W-1:0]  held_q;
	logic [NUM_PATTERNS-1:0] hits_q;

	logic [WIN_W-1:0]  wshift_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              valid_s1;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [POS_W-1:0]  out_start_q;
	logic              out_last_q;

	logic [BYTE_W-1:0] rd_data [MAX_PATTERN_LEN];
	logic [WIN_W-1:0]  rvec;
	logic [LEN_W-1:0]  len_sel;
	logic [LEN_W-1:0]  shamt;
	logic [LEN_W-1:0]  len_sat;
	logic              hit;
	logic              eq_all;
	logic [SLOT_W-1:0] emit_slot;
	logic [NUM_PATTERNS-1:0] hits_rest;

	// one byte lane per signature position, addressed by slot
	for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_lane
		mpbs_ram #(
			.WIDTH (BYTE_W),
			.DEPTH (NUM_PATTERNS)
		) u_lane (
			.clk   (clk),
			.we    (cmd.load && byte_position == BPOS_W'(k)),
			.waddr (slot_select),
			.wdata (byte_value),
			.raddr (cmd.rd_slot),
			.rdata (rd_data[k])
		);
	end

	// reversed window; shifting it by (max - len) lines byte k up with
	// the window byte that signature byte k must equal
	always_comb begin
		for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
			rvec[BYTE_W*i +: BYTE_W] = win_q[MAX_PATTERN_LEN-1-i];
		end
	end

	assign len_sel = len_q[cmd.rd_slot];
	assign shamt   = LEN_W'(MAX_PATTERN_LEN) - len_sel;
	assign len_sat = (pattern_length > LEN_W'(MAX_PATTERN_LEN)) ?
		LEN_W'(MAX_PATTERN_LEN) : pattern_length;

	always_comb begin
		eq_all = 1'b1;
		for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
			if (LEN_W'(k) < len_s1 && rd_data[k] != wshift_s1[BYTE_W*k +: BYTE_W]) begin
				eq_all = 1'b0;
			end
		end
		hit = eq_all && len_s1 != '0 && len_s1 <= held_q;
	end

	assign emit_slot = first_set(hits_q);
	assign hits_rest = hits_q & ~(NUM_PATTERNS'(1) << emit_slot);

	assign sts.hits_any = hits_q != '0;
	assign sts.hits_one = hits_rest == '0;
	assign sts.out_free = !out_valid_q || out_ready;

	// window, position, lengths, hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
				win_q[i] <= '0;
			end
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				len_q[i] <= '0;
			end
			pos_q    <= '0;
			held_q   <= '0;
			hits_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			if (cmd.set_len) begin
				len_q[slot_select] <= len_sat;
			end
			if (cmd.restart) begin
				for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
					win_q[i] <= '0;
				end
				pos_q  <= '0;
				held_q <= '0;
			end
			if (cmd.scan) begin
				win_q[0] <= byte_value;
				for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
					win_q[i] <= win_q[i-1];
				end
				if (held_q != LEN_W'(MAX_PATTERN_LEN)) begin
					held_q <= held_q + LEN_W'(1);
				end
				if (pos_q != '1) begin
					pos_q <= pos_q + POS_W'(1);
				end
				hits_q <= '0;
			end else if (valid_s1) begin
				hits_q[slot_s1] <= hit;
			end else if (cmd.emit) begin
				hits_q <= hits_rest;
			end
		end
	end

	// compare stage and offset of the current byte
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			here_q <= pos_q;
		end
		wshift_s1 <= rvec >> {shamt, 3'b000};
		len_s1    <= len_sel;
		slot_s1   <= cmd.rd_slot;
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_slot_q  <= emit_slot;
			out_start_q <= here_q - POS_W'(len_q[emit_slot]) + POS_W'(1);
			out_last_q  <= hits_rest == '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign matched_slot = out_slot_q;
	assign match_start  = out_start_q;
	assign last_match   = out_last_q;

endmodule

@@ sv/multi_pattern_byte_scanner.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_byte_scanner
// Scans a byte stream against a loaded table of byte signatures.
// ----------------------------------------------------------------------------
// Usage notes:
// - Input channel (in_valid/in_ready) carries one item per transfer: func
//   selects load signature byte, set signature length, scan byte or restart.
// - Output channel (out_valid/out_ready) carries one report per transfer:
//   slot, start offset of the match, and last_match on the final report of
//   a scan byte. Reports of one byte come in ascending slot order.
// - Load, set length and restart leave the block idle: in_ready stays
//   high.
// - A scan byte steps through the slot loop over N = active slots (min of
//   pattern_count and 16), a drain state and a report phase with one
//   report per matching slot. The slot loop reads one signature from the
//   byte lanes and compares it against the whole window per cycle. With
//   pattern_count of zero a scan byte only updates the window and
//   position and leaves the block idle.
// - in_ready stays low until the last report of a byte is in the output
//   register; that register holds it while out_ready is low, and a new item
//   can be taken meanwhile. A stalled receiver stretches the report phase.
// - Reset clears the window, position, lengths and pattern_count. The
//   signature bytes are not cleared and must be loaded before use.
// - pattern_count sits at APB word 0; write it only while idle.
// ----------------------------------------------------------------------------
module multi_pattern_byte_scanner import mpbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// APB config
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// input items
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [SLOT_W-1:0] slot_select,
	input  logic [BPOS_W-1:0] byte_position,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic [LEN_W-1:0]  pattern_length,
	// match reports
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] matched_slot,
	output logic [POS_W-1:0]  match_start,
	output logic              last_match
);

	logic [CNT_W-1:0] pcount_q;
	logic [ACT_W-1:0] active_cnt;
	cmd_t             cmd;
	sts_t             sts;

	// config register; word index from paddr[2], byte offset ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_PATTERN_COUNT) begin
			pcount_q <= pwdata[CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PATTERN_COUNT) ? APB_DW'(pcount_q) : '0;

	// slots that take part: count clamped to the table size
	assign active_cnt = (pcount_q > CNT_W'(NUM_PATTERNS)) ?
		ACT_W'(NUM_PATTERNS) : ACT_W'(pcount_q);

	mpbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.func       (func),
		.active_cnt (active_cnt),
		.sts        (sts),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	mpbs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.slot_select    (slot_select),
		.byte_position  (byte_position),
		.byte_value     (byte_value),
		.pattern_length (pattern_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.matched_slot   (matched_slot),
		.match_start    (match_start),
		.last_match     (last_match)
	);

`ifndef SYNTHESIS
	// more reports of this byte pending: no new item may be taken
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_match |-> !in_ready)
		else $error("item taken before last report");

	// a new report only comes from an emit command
	a_report_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit))
		else $error("report without emit");

	// no hits left over once the block is idle
	a_idle_no_hits: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.hits_any)
		else $error("hits pending while idle");
`endif

endmodule

@@ tb/mpbs_match_board_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpbs_match_board_pkg
// Predicts the match reports of the byte scanner and checks the reports that
// come out of the block against them, oldest first.
// ----------------------------------------------------------------------------
package mpbs_match_board_pkg;
	import mpbs_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  start;
		logic              last;
	} match_report_t;

	class match_board;
		logic [BYTE_W-1:0] sig_byte [NUM_PATTERNS][MAX_PATTERN_LEN];
		int unsigned       sig_len  [NUM_PATTERNS];
		logic [BYTE_W-1:0] history  [MAX_PATTERN_LEN]; // [0] is the newest byte
		logic [POS_W-1:0]  next_pos;
		int unsigned       depth;                      // bytes seen since restart, max 64
		int unsigned       slot_limit;                 // pattern_count
		match_report_t     due [$];
		int                errors;

		function new();
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				sig_len[i] = 0;
				for (int j = 0; j < MAX_PATTERN_LEN; j++)
					sig_byte[i][j] = '0;
			end
			clear_stream();
			slot_limit = 0;
			errors = 0;
		endfunction

		function void clear_stream();
			for (int k = 0; k < MAX_PATTERN_LEN; k++)
				history[k] = '0;
			next_pos = '0;
			depth = 0;
		endfunction

		function void set_count(logic [APB_DW-1:0] v);
			slot_limit = v[CNT_W-1:0];
		endfunction

		function int pending();
			return due.size();
		endfunction

		// signature of slot s ends at the newest byte
		function bit ends_here(int s);
			int unsigned n;
			n = sig_len[s];
			if (n == 0 || n > depth)
				return 0;
			for (int k = 0; k < n; k++)
				if (sig_byte[s][k] !== history[n - 1 - k])
					return 0;
			return 1;
		endfunction

		function void note_item(func_t f, logic [SLOT_W-1:0] s, logic [BPOS_W-1:0] p,
			logic [BYTE_W-1:0] v, logic [LEN_W-1:0] n);
			int unsigned      active;
			int               hits;
			logic [POS_W-1:0] here;
			hits = 0;
			case (f)
				FN_LOAD: sig_byte[s][p] = v;
				FN_SET_LEN: sig_len[s] = (n > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : n;
				FN_RESTART: clear_stream();
				FN_SCAN: begin
					for (int k = MAX_PATTERN_LEN - 1; k > 0; k--)
						history[k] = history[k - 1];
					history[0] = v;
					if (depth < MAX_PATTERN_LEN)
						depth++;
					here = next_pos;
					if (next_pos != '1)
						next_pos++;
					active = (slot_limit > NUM_PATTERNS) ? NUM_PATTERNS : slot_limit;
					for (int i = 0; i < active; i++) begin
						if (ends_here(i)) begin
							due.push_back('{slot: SLOT_W'(i), start: here + 1 - sig_len[i],
								last: 1'b0});
							hits++;
						end
					end
					if (hits > 0)
						due[due.size() - 1].last = 1'b1;
				end
				default: ;
			endcase
		endfunction

		function void check_report(logic [SLOT_W-1:0] s, logic [POS_W-1:0] st, logic l);
			match_report_t want;
			if (due.size() == 0) begin
				$error("matched_slot: expected no report, actual %0d (match_start %0d)", s, st);
				errors++;
				return;
			end
			want = due.pop_front();
			if (s !== want.slot) begin
				$error("matched_slot: expected %0d, actual %0d", want.slot, s);
				errors++;
			end
			if (st !== want.start) begin
				$error("match_start: expected %0d, actual %0d", want.start, st);
				errors++;
			end
			if (l !== want.last) begin
				$error("last_match: expected %0d, actual %0d", want.last, l);
				errors++;
			end
		endfunction
	endclass

endpackage

@@ tb/multi_pattern_byte_scanner_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_pattern_byte_scanner_test
// Loads signatures, scans byte streams and checks every match report against
// a predictor. Directed items first, then random phases over several
// pattern_count settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module multi_pattern_byte_scanner_test;
	import mpbs_pkg::*;
	import mpbs_match_board_pkg::*;

	// cycles with no transfer on any channel before the run is declared hung;
	// well above the long receiver hold-off
	localparam int IDLE_LIMIT  = 2000;
	// a scan byte with no hits gives no report; this wait lets it run out
	localparam int SETTLE_WAIT = 48;
	localparam int HOLD_CYCLES = 250;
	localparam int ITEM_TARGET = 300;

	localparam logic [APB_AW-1:0] ADDR_PATTERN_COUNT = APB_AW'(4 * REG_PATTERN_COUNT);
	localparam logic [APB_AW-1:0] ADDR_SPARE_WORD    = APB_AW'(4);   // word 1, no register

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	logic [SLOT_W-1:0] slot_select;
	logic [BPOS_W-1:0] byte_position;
	logic [BYTE_W-1:0] byte_value;
	logic [LEN_W-1:0]  pattern_length;
	logic              out_valid;
	logic              out_ready;
	logic [SLOT_W-1:0] matched_slot;
	logic [POS_W-1:0]  match_start;
	logic              last_match;

	// stimulus-side view of the signature table: which bytes are written, so
	// that no active signature ever covers a byte that was never loaded
	logic [MAX_PATTERN_LEN-1:0] written [NUM_PATTERNS];
	logic [BYTE_W-1:0]          sig_copy [NUM_PATTERNS][MAX_PATTERN_LEN];
	int unsigned                len_copy [NUM_PATTERNS];

	match_board board;
	int         items_done;
	int         tx_gap_pct;
	int         rx_stall_pct;
	bit         calm;       // end of run: no idling on either side
	bit         hold_req;   // ask the receiver for one long hold-off
	int         idle_cycles;

	logic [CNT_W-1:0] count_plan [6] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8};

	multi_pattern_byte_scanner uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.slot_select    (slot_select),
		.byte_position  (byte_position),
		.byte_value     (byte_value),
		.pattern_length (pattern_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.matched_slot   (matched_slot),
		.match_start    (match_start),
		.last_match     (last_match)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Helpers. Every task is entered and left right after a rising edge.
	// ------------------------------------------------------------------

	// bytes from a small alphabet so that short signatures hit often
	function automatic logic [BYTE_W-1:0] pick_sym();
		case ($urandom_range(9))
			0, 1: return BYTE_W'($urandom);
			2: return 8'h00;
			3: return 8'hFF;
			4, 5, 6: return 8'h5A;
			default: return 8'hA5;
		endcase
	endfunction

	function automatic int written_prefix(input int s);
		int n;
		n = 0;
		while (n < MAX_PATTERN_LEN && written[s][n])
			n++;
		return n;
	endfunction

	task automatic apb_write(input logic [APB_AW-1:0] a, input logic [APB_DW-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [APB_AW-1:0] a, input logic [CNT_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CNT_W-1:0] !== want) begin
			$error("pattern_count: expected %0d, actual %0d", want, prdata[CNT_W-1:0]);
			board.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one input transfer; optionally followed by a sender gap
	task automatic send_item(input func_t f, input logic [SLOT_W-1:0] s,
		input logic [BPOS_W-1:0] p, input logic [BYTE_W-1:0] v, input logic [LEN_W-1:0] n);
		in_valid <= 1'b1;
		func <= f;
		slot_select <= s;
		byte_position <= p;
		byte_value <= v;
		pattern_length <= n;
		do @(posedge clk); while (!in_ready);
		board.note_item(f, s, p, v, n);
		items_done++;
		case (f)
			FN_LOAD: begin
				written[s][p] = 1'b1;
				sig_copy[s][p] = v;
			end
			FN_SET_LEN: len_copy[s] = (n > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : n;
			default: ;
		endcase
		if (!calm && $urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// fields that an item does not use carry random junk
	task automatic load_byte(input int s, input int p, input logic [BYTE_W-1:0] v);
		send_item(FN_LOAD, SLOT_W'(s), BPOS_W'(p), v, LEN_W'($urandom));
	endtask

	task automatic set_len(input int s, input int n);
		send_item(FN_SET_LEN, SLOT_W'(s), BPOS_W'($urandom), BYTE_W'($urandom), LEN_W'(n));
	endtask

	task automatic scan_byte(input logic [BYTE_W-1:0] v);
		send_item(FN_SCAN, SLOT_W'($urandom), BPOS_W'($urandom), v, LEN_W'($urandom));
	endtask

	task automatic restart_scan();
		send_item(FN_RESTART, SLOT_W'($urandom), BPOS_W'($urandom), BYTE_W'($urandom),
			LEN_W'($urandom));
	endtask

	task automatic program_slot(input int s, input int n);
		for (int p = 0; p < n; p++)
			load_byte(s, p, pick_sym());
		set_len(s, n);
	endtask

	// mostly alphabet bytes; about one step in four replays a short signature whole
	task automatic scan_burst(input int n);
		int s;
		for (int i = 0; i < n; i++) begin
			s = $urandom_range(NUM_PATTERNS - 1);
			if ($urandom_range(3) == 0 && len_copy[s] > 0 && len_copy[s] <= 8) begin
				for (int k = 0; k < len_copy[s]; k++)
					scan_byte(sig_copy[s][k]);
			end else begin
				scan_byte(pick_sym());
			end
		end
	endtask

	// drop valid, wait for every report, then let a no-hit byte finish
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	// register write only while idle; upper data bits are random junk
	task automatic program_count(input logic [CNT_W-1:0] n);
		logic [APB_DW-1:0] word;
		word = ($urandom & ~APB_DW'(5'h1F)) | APB_DW'(n);
		settle();
		apb_write(ADDR_PATTERN_COUNT, word);
		board.set_count(word);
		apb_read_check(ADDR_PATTERN_COUNT, n);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_report(matched_slot, match_start, last_match);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99) < rx_stall_pct) begin
				stall_left = $urandom_range(1, 14) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run after too long with no transfer anywhere
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int phase;
		int pick;
		int s;
		int top;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FN_LOAD;
		slot_select = '0;
		byte_position = '0;
		byte_value = '0;
		pattern_length = '0;
		idle_cycles = 0;
		items_done = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		for (int i = 0; i < NUM_PATTERNS; i++) begin
			written[i] = '0;
			len_copy[i] = 0;
		end
		board = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register comes out of reset at zero
		apb_read_check(ADDR_PATTERN_COUNT, '0);

		// --- directed: tiny signatures, short history, restart ---
		program_count(5'd4);
		load_byte(0, 0, 8'h41);          // slot 0: "A"
		set_len(0, 1);
		load_byte(1, 0, 8'h41);          // slot 1: "AB"
		load_byte(1, 1, 8'h42);
		set_len(1, 2);
		load_byte(2, 0, 8'h00);          // slot 2: 00 FF, all bits both ways
		load_byte(2, 1, 8'hFF);
		set_len(2, 2);
		set_len(3, 0);                   // zero length: slot stays inactive
		load_byte(15, 63, 8'hFF);        // top slot, top position, not active
		scan_byte(8'h41);                // slot 1 cannot hit yet: one byte seen
		scan_byte(8'h41);
		scan_byte(8'h42);
		scan_byte(8'h00);
		scan_byte(8'hFF);
		restart_scan();
		scan_byte(8'h42);                // cleared window must not complete "AB"
		scan_byte(8'h41);
		scan_byte(8'h42);
		restart_scan();
		scan_byte(8'hFF);                // zeroed window must not complete 00 FF
		// no slot takes part at a count of zero
		program_count(5'd0);
		scan_byte(8'h41);
		scan_byte(8'h41);
		// writes to an empty address leave the count alone
		settle();
		apb_write(ADDR_SPARE_WORD, '1);
		apb_read_check(ADDR_PATTERN_COUNT, '0);

		// --- full-length signature; oversize length saturates to 64 ---
		program_count(5'd31);            // above the slot count, acts as 16
		for (int p = 0; p < MAX_PATTERN_LEN; p++)
			load_byte(15, p, BYTE_W'($urandom));
		set_len(15, 127);
		for (int p = 0; p < MAX_PATTERN_LEN; p++)
			scan_byte(sig_copy[15][p]);
		set_len(15, 65);
		for (int p = 0; p < MAX_PATTERN_LEN; p++)
			scan_byte(sig_copy[15][p]);
		set_len(15, 3);

		// --- back pressure: receiver holds off, block must stall its input ---
		program_count(5'd16);
		tx_gap_pct = 0;
		load_byte(0, 0, 8'h5A);
		set_len(0, 1);
		hold_req = 1'b1;
		repeat (12) scan_byte(8'h5A);
		settle();

		// --- random phases over several counts ---
		phase = 0;
		while (items_done < ITEM_TARGET) begin
			if (phase < 6)
				program_count(count_plan[phase]);
			else
				program_count(CNT_W'($urandom_range(31)));
			// some phases run with no idling at all
			tx_gap_pct = ($urandom_range(2) == 0) ? 0 : 25;
			rx_stall_pct = ($urandom_range(2) == 0) ? 0 : 25;
			for (int a = 0; a < 10; a++) begin
				pick = $urandom_range(99);
				s = $urandom_range(NUM_PATTERNS - 1);
				if (pick < 12) begin
					program_slot(s, ($urandom_range(4) == 0) ? $urandom_range(5, 8)
						: $urandom_range(1, 4));
				end else if (pick < 18) begin
					// new length over bytes already loaded, zero included
					top = written_prefix(s);
					if (top == MAX_PATTERN_LEN)
						set_len(s, $urandom_range(127));
					else
						set_len(s, $urandom_range(top));
				end else if (pick < 23) begin
					load_byte(s, $urandom_range(MAX_PATTERN_LEN - 1), BYTE_W'($urandom));
				end else if (pick < 28) begin
					restart_scan();
				end else begin
					scan_burst($urandom_range(2, 8));
				end
			end
			phase++;
		end

		// --- last part: no idling ---
		calm = 1'b1;
		program_count(5'd16);
		scan_burst(24);

		settle();
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
